// File: sv/assert_macros.svh
// Assertion macros used by the checker file of the serializer.
// Needs nothing else; take it in with a plain include.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property with an active-low reset that disables it
`define BVS_ASSERT_CLK(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Condition that must never be seen at a clock edge
`define BVS_ASSERT_NEVER(lbl, clk, rstn, expr, msg) \
  `BVS_ASSERT_CLK(lbl, clk, rstn, !(expr), msg)

`endif

// File: sv/bvs_pkg.sv
// Types, constants and helpers of the bit packer and varint serializer.
// Used by the front, the command queue, the back end and the top level.
`timescale 1ns / 1ps

package bvs_pkg;

  localparam int ACT_W      = 2;
  localparam int VAL_W      = 64;
  localparam int NB_W       = 4;
  localparam int BYTE_W     = 8;
  localparam int GRP_W      = 7;
  localparam int IN_TDATA_W = 72;   // value and num_bits, padded to whole bytes
  localparam int MAX_GROUPS = 10;   // a 64-bit number needs at most ten varint bytes

  localparam logic [BYTE_W-1:0] CONT_BIT   = 8'h80;
  localparam logic [GRP_W-1:0]  GROUP_MASK = 7'h7F;
  localparam logic [NB_W-1:0]   BYTE_BITS  = 4'd8;

  typedef enum logic [ACT_W-1:0] {
    ACT_BIT    = 2'd0,
    ACT_GROUP  = 2'd1,
    ACT_VARINT = 2'd2,
    ACT_RAW    = 2'd3
  } action_e;

  // What the back end has to do with one queued command
  typedef enum logic [1:0] {
    CMD_EMIT,     // byte-aligned output goes straight out
    CMD_HOLD,     // byte-aligned output goes to the hold buffer
    CMD_RELEASE   // completed pending byte, then the held bytes
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e          kind;
    logic               raw;      // single raw byte rather than a varint
    logic [NB_W-1:0]    groups;   // number of varint bytes, 1..10
    logic [VAL_W-1:0]   data;     // number, raw byte or completed pending byte
  } cmd_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_VAR,
    BK_REL_P,
    BK_REL_H
  } back_state_e;

  // Varint byte k (k = 0 is the last one sent) or the raw byte
  function automatic logic [BYTE_W-1:0] var_byte(cmd_t c, logic [NB_W-1:0] k);
    logic [GRP_W-1:0] g;
    logic [BYTE_W-1:0] b;
    unique case (k)
      4'd0:    g = c.data[6:0];
      4'd1:    g = c.data[13:7];
      4'd2:    g = c.data[20:14];
      4'd3:    g = c.data[27:21];
      4'd4:    g = c.data[34:28];
      4'd5:    g = c.data[41:35];
      4'd6:    g = c.data[48:42];
      4'd7:    g = c.data[55:49];
      4'd8:    g = c.data[62:56];
      4'd9:    g = {6'b000000, c.data[63]};
      default: g = '0;
    endcase
    g = g & GROUP_MASK;
    if (c.raw) begin
      b = c.data[BYTE_W-1:0];
    end else if (k != '0) begin
      b = CONT_BIT | {1'b0, g};
    end else begin
      b = {1'b0, g};
    end
    return b;
  endfunction

endpackage

// File: sv/bvs_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Stand-alone; holds the bytes parked while a pending byte is partly filled.
`timescale 1ns / 1ps

module bvs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read; data holds while no read is issued
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: sv/bvs_front.sv
// Front end: accepts input items, packs bits into the pending byte and
// turns each item into at most one command for the back end. Uses bvs_pkg.
`timescale 1ns / 1ps

module bvs_front import bvs_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [ACT_W-1:0] in_action_i,
  input  logic [VAL_W-1:0] in_value_i,
  input  logic [NB_W-1:0]  in_num_bits_i,
  output logic             cmd_valid_o,
  output cmd_t             cmd_o,
  input  logic             cmd_ready_i
);

  logic [BYTE_W-1:0] pending_q, pending_d;
  logic [2:0]        bitpos_q, bitpos_d;

  logic              accept;
  logic              is_group;
  logic [NB_W-1:0]   nb;
  logic [BYTE_W-1:0] grp_bits;
  logic [15:0]       acc;
  logic [NB_W-1:0]   total;
  logic [NB_W-1:0]   groups;

  // An item never needs more than one queue slot
  assign in_ready_o = cmd_ready_i;
  assign accept     = in_valid_i && cmd_ready_i;

  // Varint byte count: 7-bit slices up to the top non-zero one, at least 1
  always_comb begin
    groups = 4'd1;
    for (int j = 1; j < MAX_GROUPS; j++) begin
      groups = groups + {3'b000, (in_value_i >> (GRP_W * j)) != '0};
    end
  end

  // Bit-group width and masked bits
  always_comb begin
    is_group = 1'b0;
    nb       = '0;
    unique case (action_e'(in_action_i))
      ACT_BIT: begin
        is_group = 1'b1;
        nb       = 4'd1;
      end
      ACT_GROUP: begin
        is_group = 1'b1;
        nb       = (in_num_bits_i > BYTE_BITS) ? BYTE_BITS : in_num_bits_i;
      end
      ACT_VARINT, ACT_RAW: begin
        is_group = 1'b0;
      end
      default: begin
        is_group = 1'b0;
      end
    endcase
    grp_bits = in_value_i[BYTE_W-1:0] & ~(8'hFF << nb);
    acc      = {8'h00, pending_q} | ({8'h00, grp_bits} << bitpos_q);
    total    = {1'b0, bitpos_q} + nb;
  end

  // Classify the item and update the pending byte
  always_comb begin
    pending_d   = pending_q;
    bitpos_d    = bitpos_q;
    cmd_valid_o = 1'b0;
    cmd_o.kind  = (bitpos_q == '0) ? CMD_EMIT : CMD_HOLD;
    cmd_o.raw   = (action_e'(in_action_i) == ACT_RAW);
    cmd_o.groups = cmd_o.raw ? 4'd1 : groups;
    cmd_o.data  = in_value_i;
    if (accept) begin
      if (is_group) begin
        if (nb != '0) begin
          if (total < BYTE_BITS) begin
            pending_d = acc[7:0];
            bitpos_d  = total[2:0];
          end else begin
            cmd_valid_o = 1'b1;
            cmd_o.kind  = CMD_RELEASE;
            cmd_o.raw   = 1'b0;
            cmd_o.groups = 4'd1;
            cmd_o.data  = {56'd0, acc[7:0]};
            pending_d   = acc[15:8];
            bitpos_d    = total[2:0];
          end
        end
      end else begin
        cmd_valid_o = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= '0;
      bitpos_q  <= '0;
    end else begin
      pending_q <= pending_d;
      bitpos_q  <= bitpos_d;
    end
  end

endmodule

// File: sv/bvs_cmd_fifo.sv
// Two-entry command queue between the front and the back end.
// Uses the command struct from bvs_pkg.
`timescale 1ns / 1ps

module bvs_cmd_fifo import bvs_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t cmd_i,
  output logic ready_o,
  input  logic pop_i,
  output logic valid_o,
  output cmd_t cmd_o
);

  cmd_t       slot_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;

  assign ready_o = (count_q != 2'd2);
  assign valid_o = (count_q != 2'd0);
  assign cmd_o   = slot_q[rd_ptr_q];

  // Store on push
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= cmd_i;
    end
  end

  // Advance pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      count_q <= count_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

endmodule

// File: sv/bvs_back.sv
// Back end: runs queued commands one byte a cycle barring stalls, keeps
// the hold buffer (a bvs_ram) and a sticky overflow flag. Uses bvs_pkg.
`timescale 1ns / 1ps

module bvs_back import bvs_pkg::*; #(
  parameter int HOLD_DEPTH = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cmd_valid_i,
  input  cmd_t              cmd_i,
  output logic              cmd_pop_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [BYTE_W-1:0] out_byte_o,
  output logic              out_last_o,
  output logic              out_ovf_o
);

  localparam int AW = (HOLD_DEPTH > 1) ? $clog2(HOLD_DEPTH) : 1;
  localparam int CW = $clog2(HOLD_DEPTH + 1);

  back_state_e       state_q, state_d;
  cmd_t              cur_q, cur_d;
  logic [NB_W-1:0]   k_q, k_d;
  logic [AW-1:0]     idx_q, idx_d;
  logic [CW-1:0]     cnt_q, cnt_d;
  logic              ovf_q, ovf_d;
  logic              out_valid_q, out_valid_d;
  logic [BYTE_W-1:0] out_byte_q, out_byte_d;
  logic              out_last_q, out_last_d;
  logic              out_ovf_q, out_ovf_d;

  logic              can_push;
  logic [BYTE_W-1:0] vbyte;
  logic              ram_we, ram_re;
  logic [AW-1:0]     ram_waddr, ram_raddr;
  logic [BYTE_W-1:0] ram_rdata;

  bvs_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (HOLD_DEPTH)
  ) u_hold_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (vbyte),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign can_push = !out_valid_q || out_ready_i;
  assign vbyte    = var_byte(cur_q, k_q);

  // Sequence commands and fill the output register
  always_comb begin
    state_d     = state_q;
    cur_d       = cur_q;
    k_d         = k_q;
    idx_d       = idx_q;
    cnt_d       = cnt_q;
    ovf_d       = ovf_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_byte_d  = out_byte_q;
    out_last_d  = out_last_q;
    out_ovf_d   = out_ovf_q;
    cmd_pop_o   = 1'b0;
    ram_we      = 1'b0;
    ram_waddr   = cnt_q[AW-1:0];
    ram_re      = 1'b0;
    ram_raddr   = '0;

    unique case (state_q)
      BK_IDLE: begin
        if (cmd_valid_i) begin
          cmd_pop_o = 1'b1;
          cur_d     = cmd_i;
          k_d       = cmd_i.groups - 4'd1;
          state_d   = (cmd_i.kind == CMD_RELEASE) ? BK_REL_P : BK_VAR;
        end
      end
      BK_VAR: begin
        if (cur_q.kind == CMD_HOLD) begin
          // Park the byte, or drop it and flag overflow when full
          if (cnt_q < CW'(HOLD_DEPTH)) begin
            ram_we = 1'b1;
            cnt_d  = cnt_q + 1'b1;
          end else begin
            ovf_d = 1'b1;
          end
          k_d = k_q - 4'd1;
          if (k_q == '0) begin
            state_d = BK_IDLE;
          end
        end else if (can_push) begin
          out_valid_d = 1'b1;
          out_byte_d  = vbyte;
          out_last_d  = (k_q == '0);
          out_ovf_d   = ovf_q;
          k_d         = k_q - 4'd1;
          if (k_q == '0) begin
            state_d = BK_IDLE;
          end
        end
      end
      BK_REL_P: begin
        // Completed pending byte first; prefetch the oldest held byte
        if (can_push) begin
          out_valid_d = 1'b1;
          out_byte_d  = cur_q.data[BYTE_W-1:0];
          out_last_d  = (cnt_q == '0);
          out_ovf_d   = ovf_q;
          if (cnt_q == '0) begin
            state_d = BK_IDLE;
          end else begin
            ram_re    = 1'b1;
            ram_raddr = '0;
            idx_d     = '0;
            state_d   = BK_REL_H;
          end
        end
      end
      BK_REL_H: begin
        // Drain held bytes in arrival order, then empty the buffer
        if (can_push) begin
          out_valid_d = 1'b1;
          out_byte_d  = ram_rdata;
          out_last_d  = (CW'(idx_q) + 1'b1 == cnt_q);
          out_ovf_d   = ovf_q;
          if (CW'(idx_q) + 1'b1 == cnt_q) begin
            cnt_d   = '0;
            state_d = BK_IDLE;
          end else begin
            ram_re    = 1'b1;
            ram_raddr = idx_q + 1'b1;
            idx_d     = idx_q + 1'b1;
          end
        end
      end
      default: begin
        state_d = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      cnt_q       <= '0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      ovf_q       <= ovf_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    cur_q      <= cur_d;
    k_q        <= k_d;
    idx_q      <= idx_d;
    out_byte_q <= out_byte_d;
    out_last_q <= out_last_d;
    out_ovf_q  <= out_ovf_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;
  assign out_last_o  = out_last_q;
  assign out_ovf_o   = out_ovf_q;

endmodule

// File: sv/bit_packer_vlq_serializer.sv
// Bit packer and base-128 varint serializer. Items enter on the s_axis
// side: single bits and 1..8-bit groups fill a pending byte LSB first,
// numbers become big-endian varints with 0x80 on every byte but the last,
// raw bytes pass through; aligned bytes that arrive while the pending byte
// is partly filled are parked in a HOLD_DEPTH-byte buffer and follow the
// pending byte once it completes (extra bytes are dropped and a sticky
// overflow flag shows on tuser). The input side takes an item per cycle
// while the two-entry command queue has room; the back end takes a
// command, then sends or parks its varint bytes one by one, and a
// release sends the completed pending byte and then the held bytes.
// tlast marks the last byte that one item causes. Depends on bvs_pkg
// and the front, queue, back and RAM modules.
`timescale 1ns / 1ps

module bit_packer_vlq_serializer import bvs_pkg::*; #(
  parameter int HOLD_DEPTH = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [IN_TDATA_W-1:0] s_axis_tdata,   // [63:0] value, [67:64] num_bits, pad
  input  logic [ACT_W-1:0]      s_axis_tuser,   // [1:0] action
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [BYTE_W-1:0]     m_axis_tdata,   // [7:0] data_byte
  output logic                  m_axis_tlast,   // last
  output logic                  m_axis_tuser    // [0] overflow
);

  logic cf_push, cf_ready, cf_valid, cf_pop;
  cmd_t cf_cmd_in, cf_cmd_out;

  bvs_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (s_axis_tvalid),
    .in_ready_o    (s_axis_tready),
    .in_action_i   (s_axis_tuser),
    .in_value_i    (s_axis_tdata[VAL_W-1:0]),
    .in_num_bits_i (s_axis_tdata[VAL_W+NB_W-1:VAL_W]),
    .cmd_valid_o   (cf_push),
    .cmd_o         (cf_cmd_in),
    .cmd_ready_i   (cf_ready)
  );

  bvs_cmd_fifo u_cmd_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cf_push),
    .cmd_i   (cf_cmd_in),
    .ready_o (cf_ready),
    .pop_i   (cf_pop),
    .valid_o (cf_valid),
    .cmd_o   (cf_cmd_out)
  );

  bvs_back #(
    .HOLD_DEPTH (HOLD_DEPTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cf_valid),
    .cmd_i       (cf_cmd_out),
    .cmd_pop_o   (cf_pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_byte_o  (m_axis_tdata),
    .out_last_o  (m_axis_tlast),
    .out_ovf_o   (m_axis_tuser)
  );

endmodule

// File: sv/bvs_checker.sv
// Port-level checker for the serializer, bound to the top level below.
// Depends on assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module bvs_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [7:0]  m_axis_tdata,
  input logic        m_axis_tlast,
  input logic        m_axis_tuser
);

  logic       in_seen_q, ovf_seen_q;
  logic [9:0] out_payload, out_payload_q;
  logic       out_stall, out_beat, out_kept, ovf_lost, early_out;

  // Output handshake states and the payload of the output transaction
  assign out_stall   = m_axis_tvalid && !m_axis_tready;
  assign out_beat    = m_axis_tvalid && m_axis_tready;
  assign out_payload = {m_axis_tuser, m_axis_tlast, m_axis_tdata};
  assign out_kept    = m_axis_tvalid && (out_payload == out_payload_q);
  assign ovf_lost    = out_beat && ovf_seen_q && !m_axis_tuser;
  assign early_out   = m_axis_tvalid && !in_seen_q;

  // Hold the payload of the previous cycle
  always_ff @(posedge clk_i) begin
    out_payload_q <= out_payload;
  end

  // Track whether any item came in and whether overflow was ever shown
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_seen_q  <= 1'b0;
      ovf_seen_q <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        in_seen_q <= 1'b1;
      end
      if (out_beat && m_axis_tuser) begin
        ovf_seen_q <= 1'b1;
      end
    end
  end

  `BVS_ASSERT_CLK(a_out_held, clk_i, rst_ni, out_stall |=> out_kept, "stalled output changed")
  `BVS_ASSERT_NEVER(a_ovf_sticky, clk_i, rst_ni, ovf_lost, "overflow flag cleared")
  `BVS_ASSERT_NEVER(a_no_spurious, clk_i, rst_ni, early_out, "byte before any input transaction")

endmodule

bind bit_packer_vlq_serializer bvs_checker u_bvs_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast),
  .m_axis_tuser  (m_axis_tuser)
);
